// ===== src/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Types and constants shared by the damper sampling controller.
// ----------------------------------------------------------------------------
package dsc_pkg;

  typedef enum logic [1:0] {
    PHASE_CLOSED  = 2'd0,
    PHASE_PROBING = 2'd1,
    PHASE_OPEN    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_WAKE_LOW   = 3'd0,
    REG_WAKE_HIGH  = 3'd1,
    REG_DELTA_LOW  = 3'd2,
    REG_DELTA_HIGH = 3'd3,
    REG_CLOSED_INT = 3'd4,
    REG_PROBE_INT  = 3'd5,
    REG_OPEN_INT   = 3'd6
  } reg_idx_t;

  localparam int ADDR_W  = 5;
  localparam int TEMP_W  = 12;
  localparam int DELTA_W = 11;
  localparam int COUNT_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic signed [TEMP_W-1:0] wake_low_temp;
    logic signed [TEMP_W-1:0] wake_high_temp;
    logic [DELTA_W-1:0]       delta_low_temp;
    logic [DELTA_W-1:0]       delta_high_temp;
    logic [COUNT_W-1:0]       closed_interval;
    logic [COUNT_W-1:0]       probe_interval;
    logic [COUNT_W-1:0]       open_interval;
  } cfg_t;

endpackage

// ===== src/dsc_regs.sv =====
// ----------------------------------------------------------------------------
// dsc_regs
// APB register file holding the thresholds and phase intervals.
// ----------------------------------------------------------------------------
module dsc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dsc_pkg::cfg_t               cfg
);

  dsc_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = dsc_pkg::reg_idx_t'(paddr[dsc_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wake_low_temp   <= 12'sd0;
      cfg.wake_high_temp  <= 12'sd250;
      cfg.delta_low_temp  <= 11'd30;
      cfg.delta_high_temp <= 11'd30;
      cfg.closed_interval <= 10'd60;
      cfg.probe_interval  <= 10'd5;
      cfg.open_interval   <= 10'd60;
    end else if (wr) begin
      unique case (idx)
        dsc_pkg::REG_WAKE_LOW:   cfg.wake_low_temp   <= pwdata[11:0];
        dsc_pkg::REG_WAKE_HIGH:  cfg.wake_high_temp  <= pwdata[11:0];
        dsc_pkg::REG_DELTA_LOW:  cfg.delta_low_temp  <= pwdata[10:0];
        dsc_pkg::REG_DELTA_HIGH: cfg.delta_high_temp <= pwdata[10:0];
        dsc_pkg::REG_CLOSED_INT: cfg.closed_interval <= pwdata[9:0];
        dsc_pkg::REG_PROBE_INT:  cfg.probe_interval  <= pwdata[9:0];
        dsc_pkg::REG_OPEN_INT:   cfg.open_interval   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dsc_pkg::REG_WAKE_LOW:   prdata = {{20{cfg.wake_low_temp[11]}}, cfg.wake_low_temp};
      dsc_pkg::REG_WAKE_HIGH:  prdata = {{20{cfg.wake_high_temp[11]}}, cfg.wake_high_temp};
      dsc_pkg::REG_DELTA_LOW:  prdata = {21'd0, cfg.delta_low_temp};
      dsc_pkg::REG_DELTA_HIGH: prdata = {21'd0, cfg.delta_high_temp};
      dsc_pkg::REG_CLOSED_INT: prdata = {22'd0, cfg.closed_interval};
      dsc_pkg::REG_PROBE_INT:  prdata = {22'd0, cfg.probe_interval};
      dsc_pkg::REG_OPEN_INT:   prdata = {22'd0, cfg.open_interval};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/dsc_core.sv =====
// ----------------------------------------------------------------------------
// dsc_core
// Input register, phase/counter/motor state and result register.
// ----------------------------------------------------------------------------
module dsc_core (
  input  logic                              clk,
  input  logic                              rst,
  input  dsc_pkg::cfg_t                     cfg,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              minute_tick,
  input  logic                              stop_low_level,
  input  logic                              stop_high_level,
  input  logic signed [dsc_pkg::TEMP_W-1:0] inside_temp,
  input  logic signed [dsc_pkg::TEMP_W-1:0] outside_temp,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              motor_enable,
  output logic                              open_direction,
  output logic [1:0]                        phase_now,
  output logic                              decision_made
);

  // input register
  logic                              in_full;
  logic                              tick_q;
  logic                              s_low_q;
  logic                              s_high_q;
  logic signed [dsc_pkg::TEMP_W-1:0] inside_q;
  logic signed [dsc_pkg::TEMP_W-1:0] outside_q;

  // state, also the result payload
  dsc_pkg::phase_t                   phase;
  dsc_pkg::phase_t                   phase_next;
  logic [dsc_pkg::COUNT_W-1:0]       minute_count;
  logic [dsc_pkg::COUNT_W-1:0]       minute_count_next;
  logic                              motor_on;
  logic                              motor_on_next;
  logic                              direction;
  logic                              direction_next;
  logic                              decided;
  logic                              decided_next;

  logic                              advance;
  logic                              load;
  logic [dsc_pkg::COUNT_W-1:0]       count_inc;
  logic [dsc_pkg::COUNT_W-1:0]       interval;
  logic signed [dsc_pkg::TEMP_W:0]   diff_io;
  logic signed [dsc_pkg::TEMP_W:0]   diff_oi;
  logic signed [dsc_pkg::TEMP_W:0]   dlow;
  logic signed [dsc_pkg::TEMP_W:0]   dhigh;
  logic                              keep_open;

  assign advance    = !result_valid || result_ready;
  assign load       = in_full && advance;
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      tick_q    <= minute_tick;
      s_low_q   <= stop_low_level;
      s_high_q  <= stop_high_level;
      inside_q  <= inside_temp;
      outside_q <= outside_temp;
    end
  end

  assign diff_io = {inside_q[dsc_pkg::TEMP_W-1], inside_q}
                 - {outside_q[dsc_pkg::TEMP_W-1], outside_q};
  assign diff_oi = {outside_q[dsc_pkg::TEMP_W-1], outside_q}
                 - {inside_q[dsc_pkg::TEMP_W-1], inside_q};
  assign dlow    = $signed({2'b00, cfg.delta_low_temp});
  assign dhigh   = $signed({2'b00, cfg.delta_high_temp});

  assign keep_open = ((outside_q < cfg.wake_low_temp) && (diff_io > dlow))
                  || ((outside_q > cfg.wake_high_temp) && (diff_oi > dhigh));

  assign count_inc = (tick_q && minute_count != dsc_pkg::COUNT_MAX)
                   ? minute_count + 1'b1 : minute_count;

  always_comb begin
    case (phase)
      dsc_pkg::PHASE_PROBING: interval = cfg.probe_interval;
      dsc_pkg::PHASE_OPEN:    interval = cfg.open_interval;
      default:                interval = cfg.closed_interval;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    direction_next    = direction;
    motor_on_next     = (s_low_q == s_high_q) ? 1'b0 : motor_on;
    minute_count_next = count_inc;
    decided_next      = 1'b0;
    if (count_inc >= interval) begin
      decided_next      = 1'b1;
      minute_count_next = '0;
      if (phase == dsc_pkg::PHASE_PROBING || phase == dsc_pkg::PHASE_OPEN) begin
        if (keep_open) begin
          phase_next = dsc_pkg::PHASE_OPEN;
        end else begin
          direction_next = 1'b0;
          motor_on_next  = 1'b1;
          phase_next     = dsc_pkg::PHASE_CLOSED;
        end
      end else begin
        direction_next = 1'b1;
        motor_on_next  = 1'b1;
        phase_next     = dsc_pkg::PHASE_PROBING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dsc_pkg::PHASE_CLOSED;
      minute_count <= '0;
      motor_on     <= 1'b1;
      direction    <= 1'b0;
      decided      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= in_full;
      end
      if (load) begin
        phase        <= phase_next;
        minute_count <= minute_count_next;
        motor_on     <= motor_on_next;
        direction    <= direction_next;
        decided      <= decided_next;
      end
    end
  end

  assign motor_enable   = motor_on;
  assign open_direction = direction;
  assign phase_now      = phase;
  assign decision_made  = decided;

endmodule

// ===== src/damper_sampling_controller.sv =====
// ----------------------------------------------------------------------------
// damper_sampling_controller
// Damper motor controller that samples air by opening at set intervals.
// ----------------------------------------------------------------------------
// Items enter on item_valid/item_ready with the minute tick, both end-stop
// levels and the inside/outside temperatures. Each item yields one result on
// result_valid/result_ready: motor enable, direction, phase after the item
// and whether an interval expired.
// An accepted item is held in the input register, then the state update loads
// the result register. Throughput is one item per cycle while results are
// taken; the state update is combinational, so items can follow back to
// back.
// When the receiver stalls the result holds and one more item waits in the
// input register; item_ready then drops until the result is taken.
// Reset (rst, synchronous) empties both stages, puts the phase at closed,
// clears the minute counter, turns the motor on toward closed and restores
// the register defaults. The user must write registers over the APB port only
// while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module damper_sampling_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsc_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              minute_tick,
  input  logic                              stop_low_level,
  input  logic                              stop_high_level,
  input  logic signed [dsc_pkg::TEMP_W-1:0] inside_temp,
  input  logic signed [dsc_pkg::TEMP_W-1:0] outside_temp,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              motor_enable,
  output logic                              open_direction,
  output logic [1:0]                        phase_now,
  output logic                              decision_made
);

  dsc_pkg::cfg_t cfg;

  dsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .minute_tick     (minute_tick),
    .stop_low_level  (stop_low_level),
    .stop_high_level (stop_high_level),
    .inside_temp     (inside_temp),
    .outside_temp    (outside_temp),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .motor_enable    (motor_enable),
    .open_direction  (open_direction),
    .phase_now       (phase_now),
    .decision_made   (decision_made)
  );

endmodule

// ===== src/dsc_checker.sv =====
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks for the damper sampling controller, bound to the top.
// ----------------------------------------------------------------------------
module dsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic       motor_enable,
  input logic       open_direction,
  input logic [1:0] phase_now,
  input logic       decision_made
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> phase_now != 2'd3)
    else $error("unused phase code");

  // leaving closed starts the motor toward open
  a_probe_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && decision_made && phase_now == dsc_pkg::PHASE_PROBING
      |-> motor_enable && open_direction)
    else $error("probe start without motor toward open");

  // closing always starts the motor toward closed
  a_close_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && decision_made && phase_now == dsc_pkg::PHASE_CLOSED
      |-> motor_enable && !open_direction)
    else $error("close without motor toward closed");

endmodule

bind damper_sampling_controller dsc_checker u_dsc_checker (.*);

// ===== tb/sv/damper_sampling_controller_test.sv =====
// ----------------------------------------------------------------------------
// damper_sampling_controller_test
// Self-checking bench for the damper sampling controller.
// ----------------------------------------------------------------------------
// Drives items on the valid/ready input channel and configures the block over
// its APB port. A behavioral copy of the phase, minute counter, motor and
// direction state predicts one result per accepted item; results are checked
// in order, field by field. A directed table comes first (end stops, zero
// intervals, temperature rule edges, threshold extremes), then random phases
// with differing register settings, one of them running the longest interval.
// ----------------------------------------------------------------------------
module damper_sampling_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       motor_enable;
    logic       open_direction;
    logic [1:0] phase_now;
    logic       decision_made;
  } damper_out_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    dsc_pkg::reg_idx_t  ridx;
    int                 rval;
    logic               tick;
    logic               slo;
    logic               shi;
    int                 tin;
    int                 tout;
    bit                 typed;
    damper_out_t        want;
  } dir_row_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [dsc_pkg::ADDR_W-1:0]        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;
  logic                              item_valid = 1'b0;
  logic                              item_ready;
  logic                              minute_tick = 1'b0;
  logic                              stop_low_level = 1'b0;
  logic                              stop_high_level = 1'b0;
  logic signed [dsc_pkg::TEMP_W-1:0] inside_temp = '0;
  logic signed [dsc_pkg::TEMP_W-1:0] outside_temp = '0;
  logic                              result_valid;
  logic                              result_ready = 1'b0;
  logic                              motor_enable;
  logic                              open_direction;
  logic [1:0]                        phase_now;
  logic                              decision_made;

  damper_sampling_controller uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready),
    .minute_tick(minute_tick), .stop_low_level(stop_low_level),
    .stop_high_level(stop_high_level), .inside_temp(inside_temp),
    .outside_temp(outside_temp),
    .result_valid(result_valid), .result_ready(result_ready),
    .motor_enable(motor_enable), .open_direction(open_direction),
    .phase_now(phase_now), .decision_made(decision_made)
  );

  // model state and registers
  dsc_pkg::phase_t             st_phase;
  logic [dsc_pkg::COUNT_W-1:0] st_count;
  logic                        st_motor;
  logic                        st_dir;
  int wake_lo, wake_hi, dlt_lo, dlt_hi, ivl_closed, ivl_probe, ivl_open;

  damper_out_t pending_outs[$];
  dir_row_t    dir_rows[$];
  int          mismatches = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          streamed = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("damper_sampling_controller_test failed");
    $finish;
  end

  function automatic int clamp12(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int rand12();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic damper_out_t damper_predict(logic tick, logic slo, logic shi,
                                                 int tin, int tout);
    int          ivl;
    bit          hold;
    damper_out_t r;
    if (slo == shi) st_motor = 1'b0;
    if (tick && st_count != dsc_pkg::COUNT_MAX) st_count = st_count + 1'b1;
    case (st_phase)
      dsc_pkg::PHASE_PROBING: ivl = ivl_probe;
      dsc_pkg::PHASE_OPEN:    ivl = ivl_open;
      default:                ivl = ivl_closed;
    endcase
    r.decision_made = 1'b0;
    if (int'(st_count) >= ivl) begin
      r.decision_made = 1'b1;
      st_count = '0;
      if (st_phase == dsc_pkg::PHASE_PROBING || st_phase == dsc_pkg::PHASE_OPEN) begin
        hold = (tout < wake_lo && tin - tout > dlt_lo) ||
               (tout > wake_hi && tout - tin > dlt_hi);
        if (hold) begin
          st_phase = dsc_pkg::PHASE_OPEN;
        end else begin
          st_dir = 1'b0;
          st_motor = 1'b1;
          st_phase = dsc_pkg::PHASE_CLOSED;
        end
      end else begin
        st_dir = 1'b1;
        st_motor = 1'b1;
        st_phase = dsc_pkg::PHASE_PROBING;
      end
    end
    r.motor_enable = st_motor;
    r.open_direction = st_dir;
    r.phase_now = st_phase;
    return r;
  endfunction

  task automatic write_reg(dsc_pkg::reg_idx_t idx, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= dsc_pkg::ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dsc_pkg::REG_WAKE_LOW:   wake_lo = int'($signed(value[11:0]));
      dsc_pkg::REG_WAKE_HIGH:  wake_hi = int'($signed(value[11:0]));
      dsc_pkg::REG_DELTA_LOW:  dlt_lo = value & 'h7FF;
      dsc_pkg::REG_DELTA_HIGH: dlt_hi = value & 'h7FF;
      dsc_pkg::REG_CLOSED_INT: ivl_closed = value & 'h3FF;
      dsc_pkg::REG_PROBE_INT:  ivl_probe = value & 'h3FF;
      dsc_pkg::REG_OPEN_INT:   ivl_open = value & 'h3FF;
      default: ;
    endcase
  endtask

  task automatic send_item(logic tick, logic slo, logic shi, int tin, int tout,
                           bit typed = 0, damper_out_t want = '0);
    damper_out_t got;
    while (int'($urandom_range(0, 99)) < snd_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    minute_tick <= tick;
    stop_low_level <= slo;
    stop_high_level <= shi;
    inside_temp <= 12'(tin);
    outside_temp <= 12'(tout);
    do @(posedge clk); while (!item_ready);
    got = damper_predict(tick, slo, shi, tin, tout);
    pending_outs.push_back(typed ? want : got);
  endtask

  // block is idle once every result is back
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_temps(output int tin, output int tout);
    case ($urandom_range(0, 3))
      0: begin
        tout = clamp12(wake_lo - int'($urandom_range(1, 40)));
        tin = clamp12(tout + dlt_lo + int'($urandom_range(0, 3)) - 1);
      end
      1: begin
        tout = clamp12(wake_hi + int'($urandom_range(1, 40)));
        tin = clamp12(tout - dlt_hi - int'($urandom_range(0, 3)) + 1);
      end
      2: begin
        tout = $urandom_range(0, 1) ? wake_lo : wake_hi;
        tin = rand12();
      end
      default: begin
        tout = rand12();
        tin = rand12();
      end
    endcase
  endtask

  task automatic run_phase(int wl, int wh, int dl, int dh, int ci, int pi, int oi,
                           int n, int tick_pct);
    int tin, tout;
    drain();
    write_reg(dsc_pkg::REG_WAKE_LOW, wl);
    write_reg(dsc_pkg::REG_WAKE_HIGH, wh);
    write_reg(dsc_pkg::REG_DELTA_LOW, dl);
    write_reg(dsc_pkg::REG_DELTA_HIGH, dh);
    write_reg(dsc_pkg::REG_CLOSED_INT, ci);
    write_reg(dsc_pkg::REG_PROBE_INT, pi);
    write_reg(dsc_pkg::REG_OPEN_INT, oi);
    repeat (n) begin
      if (streamed < 513) begin
        snd_idle_pct = 23;
        rcv_idle_pct = 52;
      end else if (streamed < 1026) begin
        snd_idle_pct = 52;
        rcv_idle_pct = 23;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      pick_temps(tin, tout);
      send_item(int'($urandom_range(0, 99)) < tick_pct, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), tin, tout);
      streamed++;
    end
  endtask

  task automatic add_item(logic tick, logic slo, logic shi, int tin, int tout,
                          bit typed = 0, damper_out_t want = '0);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.ridx = dsc_pkg::REG_WAKE_LOW;
    r.rval = 0;
    r.tick = tick;
    r.slo = slo;
    r.shi = shi;
    r.tin = tin;
    r.tout = tout;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic add_reg(dsc_pkg::reg_idx_t idx, int value);
    dir_row_t r;
    r.kind = ROW_REG;
    r.ridx = idx;
    r.rval = value;
    r.tick = 1'b0;
    r.slo = 1'b0;
    r.shi = 1'b0;
    r.tin = 0;
    r.tout = 0;
    r.typed = 0;
    r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rcv_ready_draw: result_ready <= int'($urandom_range(0, 99)) >= rcv_idle_pct;
  end

  always @(posedge clk) begin
    damper_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_outs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                 $time, motor_enable, open_direction, phase_now, decision_made);
      end else begin
        want = pending_outs.pop_front();
        check_field("motor_enable", int'(want.motor_enable), int'(motor_enable));
        check_field("open_direction", int'(want.open_direction), int'(open_direction));
        check_field("phase_now", int'(want.phase_now), int'(phase_now));
        check_field("decision_made", int'(want.decision_made), int'(decision_made));
      end
    end
  end

  initial begin
    st_phase = dsc_pkg::PHASE_CLOSED;
    st_count = '0;
    st_motor = 1'b1;
    st_dir = 1'b0;
    wake_lo = 0;
    wake_hi = 250;
    dlt_lo = 30;
    dlt_hi = 30;
    ivl_closed = 60;
    ivl_probe = 5;
    ivl_open = 60;

    // after reset: homing toward closed until end stops agree
    add_item(0, 0, 1, 0, 0, 1, '{1'b1, 1'b0, dsc_pkg::PHASE_CLOSED, 1'b0});
    add_item(1, 1, 1, 2047, -2048, 1, '{1'b0, 1'b0, dsc_pkg::PHASE_CLOSED, 1'b0});
    add_item(1, 0, 0, -2048, 2047, 1, '{1'b0, 1'b0, dsc_pkg::PHASE_CLOSED, 1'b0});
    // zero intervals: acts on every item, motor start beats end-stop stop
    add_reg(dsc_pkg::REG_CLOSED_INT, 0);
    add_reg(dsc_pkg::REG_PROBE_INT, 0);
    add_reg(dsc_pkg::REG_OPEN_INT, 0);
    add_item(0, 1, 1, 0, 0, 1, '{1'b1, 1'b1, dsc_pkg::PHASE_PROBING, 1'b1});
    add_item(1, 1, 0, 100, -100);
    add_item(0, 1, 1, 200, 300);
    add_item(0, 0, 1, 280, 300);
    add_item(1, 0, 0, 0, 0);
    add_item(0, 1, 0, 29, -1);
    add_item(0, 1, 0, 0, 0);
    add_item(0, 0, 1, 30, -1);
    add_item(1, 1, 0, 220, 251);
    add_item(0, 1, 1, 0, 250);
    // thresholds at extremes: rule can never hold
    add_reg(dsc_pkg::REG_WAKE_LOW, -2048);
    add_reg(dsc_pkg::REG_WAKE_HIGH, 2047);
    add_item(1, 0, 1, 0, 0);
    add_item(0, 1, 0, 2047, -2048);
    // thresholds swapped, margins at both ends
    add_reg(dsc_pkg::REG_WAKE_LOW, 2047);
    add_reg(dsc_pkg::REG_WAKE_HIGH, -2048);
    add_reg(dsc_pkg::REG_DELTA_LOW, 0);
    add_reg(dsc_pkg::REG_DELTA_HIGH, 2047);
    add_item(0, 0, 1, 0, 0);
    add_item(0, 1, 0, 2047, -2048);
    add_item(1, 0, 1, -2048, 2047);
    add_reg(dsc_pkg::REG_DELTA_LOW, 2047);
    add_item(0, 1, 1, 2047, -2048);
    // ticks counted up to a nonzero interval
    add_reg(dsc_pkg::REG_CLOSED_INT, 1);
    add_reg(dsc_pkg::REG_PROBE_INT, 2);
    add_reg(dsc_pkg::REG_OPEN_INT, 3);
    add_item(0, 0, 1, 0, 0);
    add_item(1, 0, 1, 0, 0);
    add_item(1, 1, 0, 0, 0);
    add_item(1, 1, 0, 0, 0);
    add_item(1, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    snd_idle_pct = 23;
    rcv_idle_pct = 52;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(dir_rows[i].ridx, dir_rows[i].rval);
      end else begin
        send_item(dir_rows[i].tick, dir_rows[i].slo, dir_rows[i].shi,
                  dir_rows[i].tin, dir_rows[i].tout, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    run_phase(0, 250, 30, 30, 60, 5, 60, 200, 90);
    run_phase(rand12(), rand12(), $urandom_range(0, 100), $urandom_range(0, 100),
              0, 0, 0, 60, 50);
    run_phase(-2048, 2047, 0, 0, $urandom_range(0, 3), $urandom_range(0, 3),
              $urandom_range(0, 3), 60, 50);
    run_phase(2047, -2048, 2047, 2047, $urandom_range(1, 4), $urandom_range(1, 4),
              $urandom_range(1, 4), 60, 60);
    run_phase(rand12(), rand12(), $urandom_range(0, 2047), $urandom_range(0, 2047),
              $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7), 60, 70);
    run_phase(rand12(), rand12(), $urandom_range(0, 60), $urandom_range(0, 60),
              1023, 0, 2, 1040, 100);
    run_phase(rand12(), rand12(), $urandom_range(0, 60), $urandom_range(0, 60),
              $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5), 70, 50);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("damper_sampling_controller_test passed");
    end else begin
      $display("damper_sampling_controller_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dsc_pkg.sv
src/dsc_regs.sv
src/dsc_core.sv
src/damper_sampling_controller.sv
src/dsc_checker.sv
tb/sv/damper_sampling_controller_test.sv
